FILE: rtl/core/clbs_pkg.sv
package clbs_pkg;

	localparam logic [2:0] REQ_INIT     = 3'd0;
	localparam logic [2:0] REQ_CMD_WR   = 3'd1;
	localparam logic [2:0] REQ_DATA_WR  = 3'd2;
	localparam logic [2:0] REQ_STAT_RD  = 3'd3;
	localparam logic [2:0] REQ_DATA_RD  = 3'd4;
	localparam logic [2:0] REQ_REPLY    = 3'd5;

	localparam logic [1:0] PURP_BUSY    = 2'd0;
	localparam logic [1:0] PURP_STATUS  = 2'd1;
	localparam logic [1:0] PURP_DATA    = 2'd2;

	localparam logic       PH_IDLE      = 1'b0;
	localparam logic       PH_AWAIT     = 1'b1;

	localparam logic [7:0] INIT_BYTE    = 8'h30;
	localparam logic [7:0] INIT_4B_BYTE = 8'h20;
	localparam int         BUSY_BIT     = 7;
	localparam logic [5:0] WAIT_FIRST   = 6'd40;
	localparam logic [5:0] WAIT_NEXT    = 6'd5;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	typedef enum logic [2:0] {
		JOB_REFUSE,
		JOB_INIT,
		JOB_WRITE,
		JOB_READ,
		JOB_DONE
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		logic       rs;
		logic       fb;
		logic [7:0] data;
	} job_t;

	typedef struct packed {
		logic       strobe_res;
		logic       reg_select;
		logic       read_not_write;
		logic [7:0] bus_value;
		logic [5:0] wait_ms;
		logic       read_done;
		logic [7:0] read_value;
		logic       refused;
	} res_t;

endpackage

FILE: rtl/core/clbs_front.sv
module clbs_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic          cfg_wr_data,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    in_req,
	input  logic [7:0]    in_value,
	input  logic          q_full,
	output logic          push,
	output clbs_pkg::job_t push_job
);
	import clbs_pkg::*;

	logic       fb_q;
	logic       phase_q, phase_d;
	logic [7:0] pending_q, pending_d;
	logic       nib_q, nib_d;
	logic [3:0] hi_q, hi_d;
	logic [1:0] purp_q, purp_d;
	logic       accept;
	logic [7:0] rd_byte;
	logic       have;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		phase_d   = phase_q;
		pending_d = pending_q;
		nib_d     = nib_q;
		hi_d      = hi_q;
		purp_d    = purp_q;
		push      = 1'b0;
		push_job  = '{kind: JOB_REFUSE, rs: 1'b0, fb: fb_q, data: 8'h00};
		rd_byte   = in_value;
		have      = 1'b0;
		if (accept) begin
			if ((in_req inside {[REQ_INIT:REQ_DATA_RD]}) && phase_q != PH_IDLE) begin
				push = 1'b1;
			end else begin
				case (in_req)
					REQ_INIT: begin
						push          = 1'b1;
						push_job.kind = JOB_INIT;
					end
					REQ_CMD_WR, REQ_STAT_RD, REQ_DATA_RD: begin
						if (in_req == REQ_CMD_WR) begin
							pending_d = in_value;
						end
						purp_d = (in_req == REQ_CMD_WR) ? PURP_BUSY :
							(in_req == REQ_STAT_RD) ? PURP_STATUS : PURP_DATA;
						nib_d         = 1'b0;
						phase_d       = PH_AWAIT;
						push          = 1'b1;
						push_job.kind = JOB_READ;
						push_job.rs   = (in_req == REQ_DATA_RD);
					end
					REQ_DATA_WR: begin
						push          = 1'b1;
						push_job.kind = JOB_WRITE;
						push_job.rs   = 1'b1;
						push_job.data = in_value;
					end
					REQ_REPLY: begin
						if (phase_q == PH_AWAIT) begin
							if (nib_q) begin
								rd_byte = {hi_q, in_value[7:4]};
								nib_d   = 1'b0;
								have    = 1'b1;
							end else if (fb_q) begin
								hi_d          = in_value[7:4];
								nib_d         = 1'b1;
								push          = 1'b1;
								push_job.kind = JOB_READ;
								push_job.rs   = (purp_q == PURP_DATA);
							end else begin
								have = 1'b1;
							end
							if (have) begin
								push = 1'b1;
								if (purp_q == PURP_BUSY) begin
									if (rd_byte[BUSY_BIT]) begin
										nib_d         = 1'b0;
										push_job.kind = JOB_READ;
									end else begin
										phase_d       = PH_IDLE;
										push_job.kind = JOB_WRITE;
										push_job.data = pending_q;
									end
								end else begin
									phase_d       = PH_IDLE;
									push_job.kind = JOB_DONE;
									push_job.data = rd_byte;
								end
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_q      <= 1'b1;
			phase_q   <= PH_IDLE;
			pending_q <= 8'h00;
			nib_q     <= 1'b0;
			hi_q      <= 4'h0;
			purp_q    <= PURP_BUSY;
		end else begin
			if (cfg_wr_en) begin
				fb_q <= cfg_wr_data;
			end
			phase_q   <= phase_d;
			pending_q <= pending_d;
			nib_q     <= nib_d;
			hi_q      <= hi_d;
			purp_q    <= purp_d;
		end
	end

endmodule

FILE: rtl/core/clbs_queue.sv
module clbs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  clbs_pkg::job_t push_job,
	output logic           full,
	output logic           q_valid,
	output clbs_pkg::job_t head_job,
	input  logic           pop
);
	import clbs_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push, do_pop;

	assign full     = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign q_valid  = (cnt_q != '0);
	assign head_job = mem_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (QPTR_W+1)'(1);
				2'b01:   cnt_q <= cnt_q - (QPTR_W+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/clbs_back.sv
module clbs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  clbs_pkg::job_t head_job,
	output logic           pop,
	output logic           out_valid,
	input  logic           out_ready,
	output clbs_pkg::res_t out_res,
	output logic           out_last
);
	import clbs_pkg::*;

	logic [1:0] step_q;
	logic [1:0] last_idx;
	logic       is_last;
	logic       fire;
	logic       out_valid_q;
	res_t       res_q, res;
	logic       last_q;

	always_comb begin
		case (head_job.kind)
			JOB_INIT:  last_idx = head_job.fb ? 2'd3 : 2'd2;
			JOB_WRITE: last_idx = head_job.fb ? 2'd1 : 2'd0;
			default:   last_idx = 2'd0;
		endcase
	end

	assign is_last = (step_q == last_idx);
	assign fire    = q_valid && (!out_valid_q || out_ready);
	assign pop     = fire && is_last;

	always_comb begin
		res = '0;
		case (head_job.kind)
			JOB_REFUSE: begin
				res.refused = 1'b1;
			end
			JOB_INIT: begin
				res.strobe_res = 1'b1;
				res.bus_value  = (step_q == 2'd3) ? INIT_4B_BYTE : INIT_BYTE;
				res.wait_ms    = (step_q == 2'd0) ? WAIT_FIRST : WAIT_NEXT;
			end
			JOB_WRITE: begin
				res.strobe_res = 1'b1;
				res.reg_select = head_job.rs;
				if (!head_job.fb) begin
					res.bus_value = head_job.data;
				end else if (step_q == 2'd0) begin
					res.bus_value = {head_job.data[7:4], 4'h0};
				end else begin
					res.bus_value = {head_job.data[3:0], 4'h0};
				end
			end
			JOB_READ: begin
				res.strobe_res     = 1'b1;
				res.reg_select     = head_job.rs;
				res.read_not_write = 1'b1;
			end
			JOB_DONE: begin
				res.read_done  = 1'b1;
				res.read_value = head_job.data;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q  <= res;
			last_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q      <= 2'd0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
				step_q      <= is_last ? 2'd0 : step_q + 2'd1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;
	assign out_last  = last_q;

endmodule

FILE: rtl/core/char_lcd_bus_sequencer.sv
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  tuser req_type, tdata value
// m_*       out  m_tvalid/m_tready  tuser strobe_res, tdata result fields, tlast last
// cfg_*     in   cfg_wr_en          cfg_wr_data four_bit_mode
//
// a request is classified in the cycle it is taken and queued as one job
// the back end emits one result per cycle unless m_tready stalls it
// a request has 1 to 4 results (init is 3 or 4), counted by the back end step counter
// requests that give no result never reach the queue
// s_tready drops only while the four-entry job queue is full; m_tready stalls the back end
// reset clears the queue, m_tvalid and the sequencer state; four_bit_mode resets to 1
module char_lcd_bus_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // value
	input  logic [2:0]  s_tuser,  // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // reg_select, read_not_write, bus_value, wait_ms,
	                              // read_done, read_value, refused
	output logic [0:0]  m_tuser,  // strobe_res
	output logic        m_tlast
);
	import clbs_pkg::*;

	logic push, q_full, q_valid, pop;
	job_t push_job, head_job;
	res_t out_res;

	clbs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_req     (s_tuser),
		.in_value   (s_tdata),
		.q_full     (q_full),
		.push       (push),
		.push_job   (push_job)
	);

	clbs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (q_full),
		.q_valid (q_valid),
		.head_job(head_job),
		.pop     (pop)
	);

	clbs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.head_job (head_job),
		.pop      (pop),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_res  (out_res),
		.out_last (m_tlast)
	);

	assign m_tuser = out_res.strobe_res;
	assign m_tdata = {6'b0, out_res.refused, out_res.read_value, out_res.read_done,
		out_res.wait_ms, out_res.bus_value, out_res.read_not_write, out_res.reg_select};

	a_push_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		push && !q_valid && (!m_tvalid || m_tready) |-> ##2 m_tvalid)
		else $error("queued job did not reach the output register");

	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> m_tvalid && m_tlast)
		else $error("job retired without a last result");

	a_read_strobe_releases_bus: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] && m_tdata[1] |-> m_tdata[9:2] == 8'h00)
		else $error("read strobe drives the data lines");

endmodule
